// File: hdl/gcdist_pkg.sv
// Package with the constants, constant-table builders and angle helpers of the distance pipeline.
package gcdist_pkg;

  localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
  localparam logic signed [33:0] FULL_TURN = 34'sd3600000000;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;
  localparam logic [63:0] UNITS_QUARTER = 64'd900000000;
  localparam logic [30:0] EARTH_DIAM_CM = 31'd1274200000;
  localparam logic [30:0] DIST_MAX = 31'h7FFFFFFF;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] power;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] k;
    power = udiv64(64'h4000000000000000, n);
    sum = '0;
    k = '0;
    while (power != 64'd0) begin
      term = udiv64(power, 64'd2 * k + 64'd1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      power = udiv64(udiv64(power, n), n);
      k = k + 64'd1;
    end
    return sum;
  endfunction

  localparam logic [63:0] QUARTER = atan_inv(64'd2) + atan_inv(64'd3);
  localparam logic [63:0] C92 = ((QUARTER / UNITS_QUARTER) << 30) +
                                (((QUARTER % UNITS_QUARTER) << 30) / UNITS_QUARTER);

  function automatic logic [63:0] tab_entry(input int i, input int f);
    logic [63:0] q;
    int sh;
    sh = 62 - f;
    q = (i == 0) ? QUARTER : atan_inv(64'd1 << i);
    return (q + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] cordic_kinv(input int f, input int n);
    logic [63:0] g;
    logic [63:0] y;
    logic [63:0] t;
    logic [127:0] v;
    int k;
    g = 64'd1 << 62;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        g = g >> 1;
      end else if (2 * i < 63) begin
        y = g;
        t = g >> (2 * i);
        k = 0;
        while (t != 64'd0) begin
          if ((k & 1) != 0) y = y + t;
          else y = y - t;
          k = k + 1;
          t = t >> (2 * i);
        end
        g = y;
      end
    end
    if (2 * f >= 62) v = {64'd0, g} << (2 * f - 62);
    else v = {64'd0, g >> (62 - 2 * f)};
    return isqrt128(v);
  endfunction

  function automatic logic signed [33:0] wrap_turn(input logic signed [33:0] d);
    logic signed [33:0] r;
    r = d;
    if (d > HALF_TURN) r = d - FULL_TURN;
    else if (d <= -HALF_TURN) r = d + FULL_TURN;
    return r;
  endfunction

endpackage

// File: hdl/great_circle_distance.sv
// Pipelined haversine great-circle distance between two points, in centimeters.
//
// Usage: present both points on the input ports and raise start for one cycle per
// beat; busy is always low, so a beat is taken at every edge where start is high.
// Angles are signed, in units of 1e-7 degree. Each beat yields exactly one result:
// distance_cm is valid in the single cycle where done is high.
// Throughput is one beat per cycle. The depth is set by the four rotation CORDIC
// lanes (one stage per iteration), the two bit-per-stage square roots
// (ANGLE_FRAC_BITS + 1 stages) and the vectoring CORDIC for the arcsine (one stage
// per iteration).
// Reset clears every valid bit in the pipeline; beats in flight are dropped and done
// stays low until new beats arrive. The receiver cannot stall, so the pipeline never
// holds and a result is never repeated or lost.
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = 30,
  parameter int TRIG_ITERATIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] first_latitude,
  input  logic signed [31:0] first_longitude,
  input  logic signed [30:0] second_latitude,
  input  logic signed [31:0] second_longitude,
  output logic               done,
  output logic        [30:0] distance_cm
);
  import gcdist_pkg::*;

  localparam int F = ANGLE_FRAC_BITS;
  localparam int N = TRIG_ITERATIONS;
  localparam int W = F + 3;
  localparam int RW = 2 * F + 2;
  localparam int PW = W + 31;
  localparam logic [63:0] KINV = cordic_kinv(F, N);
  localparam logic [2*W-1:0] RND = (2 * W)'(1) << (F - 1);
  localparam logic signed [W:0] ONE = (W + 1)'(1) << F;

  assign busy = 1'b0;

  logic v0;
  logic signed [30:0] lat1_q;
  logic signed [30:0] lat2_q;
  logic signed [31:0] lon1_q;
  logic signed [31:0] lon2_q;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start;
    lat1_q <= first_latitude;
    lat2_q <= second_latitude;
    lon1_q <= first_longitude;
    lon2_q <= second_longitude;
  end

  logic signed [33:0] pre [4];
  logic [1:0] fold_c;

  always_comb begin
    pre[0] = wrap_turn(34'(lat2_q) - 34'(lat1_q));
    pre[1] = wrap_turn(34'(lon2_q) - 34'(lon1_q));
    pre[2] = 34'(lat1_q);
    pre[3] = 34'(lat2_q);
    fold_c = 2'b00;
    for (int l = 2; l < 4; l++) begin
      if (34'(lat1_q) == pre[2] && l == 2 || l == 3) begin
        if (pre[l] > QUARTER_TURN) begin
          pre[l] = HALF_TURN - pre[l];
          fold_c[l-2] = 1'b1;
        end else if (pre[l] < -QUARTER_TURN) begin
          pre[l] = -HALF_TURN - pre[l];
          fold_c[l-2] = 1'b1;
        end
      end
    end
  end

  logic s1_v;
  logic [30:0] s1_mag [4];
  logic [3:0] s1_sgn;
  logic [1:0] s1_fold;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= v0;
    for (int l = 0; l < 4; l++) begin
      s1_sgn[l] <= pre[l][33];
      s1_mag[l] <= pre[l][33] ? 31'(-pre[l]) : 31'(pre[l]);
    end
    s1_fold <= fold_c;
  end

  logic s2_v;
  logic [61:0] s2_lo [4];
  logic [61:0] s2_hi [4];
  logic [3:0] s2_sgn;
  logic [1:0] s2_fold;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
    for (int l = 0; l < 4; l++) begin
      s2_lo[l] <= 62'(s1_mag[l]) * 62'(C92[30:0]);
      s2_hi[l] <= 62'(s1_mag[l]) * 62'(C92[61:31]);
    end
    s2_sgn <= s1_sgn;
    s2_fold <= s1_fold;
  end

  logic cv [N+1];
  logic [1:0] cfold [N+1];
  logic signed [W-1:0] cx [N+1][4];
  logic signed [W-1:0] cy [N+1][4];
  logic signed [W-1:0] cz [N+1][4];

  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else cv[0] <= s2_v;
    cfold[0] <= s2_fold;
  end

  for (genvar l = 0; l < 4; l++) begin : g_angle
    localparam int SH = (l < 2) ? 92 - F : 91 - F;
    logic [93:0] sum;
    logic [W-1:0] mag;
    assign sum = (94'(s2_hi[l]) << 31) + 94'(s2_lo[l]) + (94'(1) << (SH - 1));
    assign mag = W'(sum >> SH);
    always_ff @(posedge clk) begin
      cx[0][l] <= W'(KINV);
      cy[0][l] <= '0;
      cz[0][l] <= s2_sgn[l] ? -signed'(mag) : signed'(mag);
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    localparam logic signed [W-1:0] ANG = W'(tab_entry(k, F));
    always_ff @(posedge clk) begin
      if (rst) cv[k+1] <= 1'b0;
      else cv[k+1] <= cv[k];
      cfold[k+1] <= cfold[k];
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (cz[k][l] >= 0) begin
          cx[k+1][l] <= cx[k][l] - (cy[k][l] >>> k);
          cy[k+1][l] <= cy[k][l] + (cx[k][l] >>> k);
          cz[k+1][l] <= cz[k][l] - ANG;
        end else begin
          cx[k+1][l] <= cx[k][l] + (cy[k][l] >>> k);
          cy[k+1][l] <= cy[k][l] - (cx[k][l] >>> k);
          cz[k+1][l] <= cz[k][l] + ANG;
        end
      end
    end
  end

  logic signed [2*W-1:0] uu_p;
  logic signed [2*W-1:0] vv_p;
  logic [W-1:0] c1_m;
  logic [W-1:0] c2_m;
  logic [2*W-1:0] cc_p;

  assign uu_p = cy[N][0] * cy[N][0];
  assign vv_p = cy[N][1] * cy[N][1];
  assign c1_m = cx[N][2][W-1] ? W'(-cx[N][2]) : W'(cx[N][2]);
  assign c2_m = cx[N][3][W-1] ? W'(-cx[N][3]) : W'(cx[N][3]);
  assign cc_p = (2 * W)'(c1_m) * (2 * W)'(c2_m);

  logic p1_v;
  logic [W-1:0] p1_uu;
  logic [W-1:0] p1_vv;
  logic [W-1:0] p1_cc;
  logic p1_neg;

  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else p1_v <= cv[N];
    p1_uu <= W'((unsigned'(uu_p) + RND) >> F);
    p1_vv <= W'((unsigned'(vv_p) + RND) >> F);
    p1_cc <= W'((cc_p + RND) >> F);
    p1_neg <= cx[N][2][W-1] ^ cfold[N][0] ^ cx[N][3][W-1] ^ cfold[N][1];
  end

  logic [2*W-1:0] t_p;
  assign t_p = (2 * W)'(p1_cc) * (2 * W)'(p1_vv);

  logic p2_v;
  logic [W-1:0] p2_uu;
  logic [W-1:0] p2_t;
  logic p2_neg;

  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else p2_v <= p1_v;
    p2_uu <= p1_uu;
    p2_t <= W'((t_p + RND) >> F);
    p2_neg <= p1_neg;
  end

  logic signed [W+1:0] a_raw;
  logic signed [W:0] a_sat;

  always_comb begin
    a_raw = p2_neg ? (W + 2)'(p2_uu) - (W + 2)'(p2_t) : (W + 2)'(p2_uu) + (W + 2)'(p2_t);
    if (a_raw < 0) a_sat = '0;
    else if (a_raw > (W + 2)'(ONE)) a_sat = ONE;
    else a_sat = (W + 1)'(a_raw);
  end

  logic sv [F+2];
  logic [RW-1:0] srem [F+2][2];
  logic [F:0] sroot [F+2][2];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else sv[0] <= p2_v;
    srem[0][0] <= RW'(unsigned'(a_sat)) << F;
    srem[0][1] <= RW'(unsigned'(ONE - a_sat)) << F;
    sroot[0][0] <= '0;
    sroot[0][1] <= '0;
  end

  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    localparam int B = F - j;
    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else sv[j+1] <= sv[j];
    end
    for (genvar q = 0; q < 2; q++) begin : g_root
      logic [RW-1:0] trial;
      assign trial = (RW'(sroot[j][q]) << (B + 1)) + (RW'(1) << (2 * B));
      always_ff @(posedge clk) begin
        if (srem[j][q] >= trial) begin
          srem[j+1][q] <= srem[j][q] - trial;
          sroot[j+1][q] <= sroot[j][q] | ((F + 1)'(1) << B);
        end else begin
          srem[j+1][q] <= srem[j][q];
          sroot[j+1][q] <= sroot[j][q];
        end
      end
    end
  end

  logic vv [N+1];
  logic signed [W-1:0] vx [N+1];
  logic signed [W-1:0] vy [N+1];
  logic signed [W-1:0] vz [N+1];

  always_ff @(posedge clk) begin
    if (rst) vv[0] <= 1'b0;
    else vv[0] <= sv[F+1];
    vx[0] <= W'(sroot[F+1][1]);
    vy[0] <= W'(sroot[F+1][0]);
    vz[0] <= '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_vec
    localparam logic signed [W-1:0] ANG = W'(tab_entry(k, F));
    always_ff @(posedge clk) begin
      if (rst) vv[k+1] <= 1'b0;
      else vv[k+1] <= vv[k];
      if (vy[k] >= 0) begin
        vx[k+1] <= vx[k] + (vy[k] >>> k);
        vy[k+1] <= vy[k] - (vx[k] >>> k);
        vz[k+1] <= vz[k] + ANG;
      end else begin
        vx[k+1] <= vx[k] - (vy[k] >>> k);
        vy[k+1] <= vy[k] + (vx[k] >>> k);
        vz[k+1] <= vz[k] - ANG;
      end
    end
  end

  logic [W-1:0] z_m;
  assign z_m = vz[N][W-1] ? W'(-vz[N]) : W'(vz[N]);

  logic m1_v;
  logic m1_neg;
  logic [PW-1:0] m1_p;

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else m1_v <= vv[N];
    m1_neg <= vz[N][W-1];
    m1_p <= PW'(z_m) * PW'(EARTH_DIAM_CM);
  end

  logic [PW-1:0] d_full;
  assign d_full = (m1_p + (PW'(1) << (F - 1))) >> F;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= m1_v;
    if (m1_neg) distance_cm <= '0;
    else if (d_full > PW'(DIST_MAX)) distance_cm <= DIST_MAX;
    else distance_cm <= 31'(d_full);
  end

endmodule

// File: hdl/gcdist_check.sv
// Port-level checker for the distance pipeline, with its bind to the top level.
module gcdist_check #(
  parameter int ANGLE_FRAC_BITS = 30,
  parameter int TRIG_ITERATIONS = 32
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [30:0] distance_cm
);
  localparam int LAT = 2 * TRIG_ITERATIONS + ANGLE_FRAC_BITS + 11;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a beat at the pipeline latency");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> distance_cm <= 31'd2002000000)
    else $error("distance beyond half the circumference");

endmodule

bind great_circle_distance gcdist_check #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
  .TRIG_ITERATIONS(TRIG_ITERATIONS)
) u_gcdist_check (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .distance_cm(distance_cm)
);

// File: tb/tb.sv
// Testbench for the pipelined great-circle distance block, checked against a fixed-point predictor.
`timescale 1ns / 1ps

module tb;

  localparam int FRAC = 30;
  localparam int ITERS = 32;
  localparam int PIPE_DEPTH = 2 * ITERS + FRAC + 10;
  localparam longint RADIUS_CM = 637100000;
  localparam longint HALF_UNITS = 1800000000;
  localparam int RANDOM_BEATS = 1950;

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    bit                 known;
    logic        [30:0] dist_cm;
  } point_pair_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [30:0] first_latitude = '0;
  logic signed [31:0] first_longitude = '0;
  logic signed [30:0] second_latitude = '0;
  logic signed [31:0] second_longitude = '0;
  logic               done;
  logic        [30:0] distance_cm;

  logic [30:0] pending_dist[$];
  logic [30:0] next_dist;
  int          errors = 0;
  longint      atan_tab[ITERS];
  longint      gain_inv;
  longint      rad_per_unit;

  great_circle_distance i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_latitude(first_latitude),
    .first_longitude(first_longitude),
    .second_latitude(second_latitude),
    .second_longitude(second_longitude),
    .done(done),
    .distance_cm(distance_cm)
  );

  always #5 clk = ~clk;

  function automatic longint round_mul(longint a, longint b, int s);
    logic [127:0] p;
    logic [63:0]  ua;
    logic [63:0]  ub;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (s - 1))) >> s;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint floor_root(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 44; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic logic [63:0] arctan_recip(logic [63:0] n);
    logic [63:0] power;
    logic [63:0] sum;
    logic [63:0] k;
    power = (64'd1 << 62) / n;
    sum = '0;
    k = '0;
    while (power != 0) begin
      if (k[0]) sum = sum - power / (2 * k + 1);
      else sum = sum + power / (2 * k + 1);
      power = power / n / n;
      k++;
    end
    return sum;
  endfunction

  function automatic void build_constants();
    logic [63:0] quarter;
    logic [63:0] q;
    logic [63:0] g;
    logic [63:0] y;
    logic [63:0] t;
    int          k;
    quarter = arctan_recip(2) + arctan_recip(3);
    g = 64'd1 << 62;
    for (int i = 0; i < ITERS; i++) begin
      q = (i == 0) ? quarter : arctan_recip(64'd1 << i);
      atan_tab[i] = longint'((q + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
      if (i == 0) begin
        g = g >> 1;
      end else if (2 * i < 63) begin
        y = g;
        t = g;
        k = 0;
        forever begin
          t = t >> (2 * i);
          if (t == 0) break;
          if (k % 2 == 1) y = y + t;
          else y = y - t;
          k++;
        end
        g = y;
      end
    end
    if (2 * FRAC >= 62) gain_inv = floor_root({64'd0, g} << (2 * FRAC - 62));
    else gain_inv = floor_root({64'd0, g >> (62 - 2 * FRAC)});
    rad_per_unit = longint'(((quarter / 64'd900000000) << 30) +
                            (((quarter % 64'd900000000) << 30) / 64'd900000000));
  endfunction

  function automatic void cordic_rotate(longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = gain_inv;
    y = 0;
    z = ang;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint wrap_half_turn(longint d);
    while (d > HALF_UNITS) d -= 2 * HALF_UNITS;
    while (d <= -HALF_UNITS) d += 2 * HALF_UNITS;
    return d;
  endfunction

  function automatic longint latitude_cosine(longint lat);
    longint c;
    longint s;
    bit     neg;
    neg = 1'b0;
    if (lat > HALF_UNITS / 2) begin
      lat = HALF_UNITS - lat;
      neg = 1'b1;
    end else if (lat < -(HALF_UNITS / 2)) begin
      lat = -HALF_UNITS - lat;
      neg = 1'b1;
    end
    cordic_rotate(round_mul(lat, rad_per_unit, 91 - FRAC), c, s);
    return neg ? -c : c;
  endfunction

  function automatic logic [30:0] haversine_cm(point_pair_t p);
    longint one;
    longint junk;
    longint u;
    longint v;
    longint c1;
    longint c2;
    longint a;
    longint z;
    longint d;
    one = longint'(1) << FRAC;
    cordic_rotate(round_mul(wrap_half_turn(longint'(p.lat_b) - longint'(p.lat_a)),
                            rad_per_unit, 92 - FRAC), junk, u);
    cordic_rotate(round_mul(wrap_half_turn(longint'(p.lon_b) - longint'(p.lon_a)),
                            rad_per_unit, 92 - FRAC), junk, v);
    c1 = latitude_cosine(p.lat_a);
    c2 = latitude_cosine(p.lat_b);
    a = round_mul(u, u, FRAC) +
        round_mul(round_mul(c1, c2, FRAC), round_mul(v, v, FRAC), FRAC);
    if (a < 0) a = 0;
    if (a > one) a = one;
    z = cordic_angle(floor_root({64'd0, a} << FRAC), floor_root({64'd0, one - a} << FRAC));
    d = round_mul(z, 2 * RADIUS_CM, FRAC);
    if (d < 0) d = 0;
    if (d > 64'h7FFFFFFF) d = 64'h7FFFFFFF;
    return d[30:0];
  endfunction

  function automatic logic signed [30:0] any_latitude(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return $urandom_range(1, 0) ? 31'sd900000000 : -31'sd900000000;
      default: return 31'(longint'($urandom_range(1800000000, 0)) - 900000000);
    endcase
  endfunction

  function automatic logic signed [31:0] any_longitude(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'sd1800000000 : -32'sd1800000000;
      default: return 32'(longint'($urandom_range(32'd3600000000, 0)) - HALF_UNITS);
    endcase
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int          mode;
    mode = $urandom_range(9, 0);
    p.lat_a = any_latitude(mode == 0 ? 0 : (mode == 1 ? 1 : 2));
    p.lon_a = any_longitude(mode == 0 ? 0 : (mode == 1 ? 1 : 2));
    p.lat_b = any_latitude(mode == 0 ? 0 : ($urandom_range(5, 0) == 0 ? 1 : 2));
    p.lon_b = any_longitude(mode == 0 ? 0 : ($urandom_range(5, 0) == 0 ? 1 : 2));
    if (mode == 2) begin
      p.lat_b = p.lat_a + 31'($urandom_range(2000, 0)) - 31'sd1000;
      p.lon_b = p.lon_a + 32'($urandom_range(2000000, 0)) - 32'sd1000000;
    end
    p.known = 1'b0;
    p.dist_cm = '0;
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual distance_cm %0d",
                 $time, distance_cm);
        errors++;
      end else begin
        next_dist = pending_dist.pop_front();
        if (distance_cm !== next_dist) begin
          $display("%0t: distance_cm mismatch, expected %0d, actual %0d",
                   $time, next_dist, distance_cm);
          errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    point_pair_t directed[$];
    point_pair_t p;
    int          total;
    int          sent;
    int          drain;
    build_constants();
    directed.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd0, 1'b0, 31'd0});
    directed.push_back('{31'sd900000000, 32'sd1800000000, 31'sd900000000,
                         32'sd1800000000, 1'b0, 31'd0});
    directed.push_back('{-31'sd900000000, -32'sd1800000000, -31'sd900000000,
                         -32'sd1800000000, 1'b0, 31'd0});
    directed.push_back('{31'sd0, 32'sd1800000000, 31'sd0, -32'sd1800000000, 1'b0, 31'd0});
    directed.push_back('{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0, 1'b0, 31'd0});
    directed.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000, 1'b0, 31'd0});
    directed.push_back('{31'sd0, -32'sd1700000000, 31'sd0, 32'sd1700000000, 1'b0, 31'd0});
    directed.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd1, 1'b0, 31'd0});
    directed.push_back('{31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000,
                         1'b0, 31'd0});
    directed.push_back('{31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF,
                         1'b0, 31'd0});
    directed.push_back('{31'sh3FFFFFFF, 32'sd0, 31'sh3FFFFFFF, 32'sd0, 1'b0, 31'd0});
    directed.push_back('{31'sd450000000, 32'sd100000000, -31'sd450000000,
                         -32'sd1700000000, 1'b0, 31'd0});
    directed.push_back('{-31'sd1, -32'sd1, 31'sd0, 32'sd0, 1'b0, 31'd0});
    directed.push_back('{31'sd523000000, 32'sd134000000, 31'sd488000000,
                         32'sd23000000, 1'b0, 31'd0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    total = directed.size() + RANDOM_BEATS;
    sent = 0;
    while (sent < total) begin
      @(posedge clk);
      if (start && !busy) begin
        sent++;
        if (sent == total) begin
          start <= 1'b0;
          break;
        end
      end
      if (!(start && busy)) begin
        if ((sent < 700 || sent > 1100) && $urandom_range(99, 0) < 17) begin
          start <= 1'b0;
        end else begin
          p = (sent < directed.size()) ? directed[sent] : random_pair();
          pending_dist.push_back(p.known ? p.dist_cm : haversine_cm(p));
          first_latitude <= p.lat_a;
          first_longitude <= p.lon_a;
          second_latitude <= p.lat_b;
          second_longitude <= p.lon_b;
          start <= 1'b1;
        end
      end
    end
    drain = 0;
    while (pending_dist.size() != 0 && drain < 20 * PIPE_DEPTH) begin
      @(posedge clk);
      drain++;
    end
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/gcdist_pkg.sv
hdl/great_circle_distance.sv
hdl/gcdist_check.sv
tb/tb.sv
